// ----- src/dpid_pkg.sv -----
// Shared types and constants for the discrete PID controller.
// Used by the serial multiplier, the top level and the testbench; depends on nothing.
`default_nettype none

package dpid_pkg;

  // Serial multiplier geometry: a wide signed multiplicand times a 16-bit multiplier.
  localparam int unsigned MCAND_W = 48;
  localparam int unsigned MPLR_W  = 16;
  localparam int unsigned PROD_W  = MCAND_W + MPLR_W;
  localparam int unsigned CNT_W   = $clog2(MPLR_W);

  // Fixed-point store widths.
  localparam int unsigned INTEG_W = 40;
  localparam int unsigned MID_W   = 48;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned GAIN_W  = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD = 3'd4;

  // Request to the serial multiplier.
  typedef struct packed {
    logic start;
    logic mplr_signed;
  } smul_ctrl_t;

endpackage

`default_nettype wire

// ----- src/discrete_pid_controller_top.sv -----
// Discrete PID controller: error, derivative, saturating integral and drive in fixed point.
// Depends on dpid_pkg and the serial multiplier dpid_smul.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   input   | in        | in_valid_i/in_stall_o | target_i, measured_i
//   output  | out       | out_valid_o/out_stall_i | drive_o, clipped_o
//   config  | in        | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One request runs from acceptance to the next acceptance in these steps: five
// multiplications run through the one shift-add multiplier at one multiplier
// bit per cycle, plus two saturation steps and the hand-off.
// Reset clears the integral, the previous error and the gains to their defaults.
// A finished result waits in the output register; a new request is taken
// while it waits, and the next result holds in the last step until it drains.
`default_nettype none

module discrete_pid_controller_top #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          cfg_we_i,
  input  wire logic [dpid_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [dpid_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  wire                                          in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          target_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          measured_i,
  output logic                                         out_valid_o,
  input  wire                                          out_stall_i,
  output logic signed [dpid_pkg::DRIVE_W-1:0]          drive_o,
  output logic                                         clipped_o
);
  import dpid_pkg::*;

  localparam int unsigned EW = SAMPLE_WIDTH + 1;
  localparam int unsigned DW = SAMPLE_WIDTH + 2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MD   = 4'd1;
  localparam logic [3:0] ST_WD   = 4'd2;
  localparam logic [3:0] ST_MI   = 4'd3;
  localparam logic [3:0] ST_WI   = 4'd4;
  localparam logic [3:0] ST_CI   = 4'd5;
  localparam logic [3:0] ST_MK   = 4'd6;
  localparam logic [3:0] ST_WK   = 4'd7;
  localparam logic [3:0] ST_ML   = 4'd8;
  localparam logic [3:0] ST_WL   = 4'd9;
  localparam logic [3:0] ST_CL   = 4'd10;
  localparam logic [3:0] ST_MP   = 4'd11;
  localparam logic [3:0] ST_WP   = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0] state_q, state_d;

  logic [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q, period_q, inv_period_q;

  logic signed [EW-1:0]      last_error_q, last_error_d;
  logic signed [INTEG_W-1:0] integral_q, integral_d;
  logic signed [EW-1:0]      e_q, e_d;
  logic signed [DW-1:0]      diff_q, diff_d;
  logic signed [MID_W-1:0]   deriv_q, deriv_d;
  logic signed [INTEG_W:0]   isum_unused;
  logic signed [PROD_W:0]    isum_q, isum_d;
  logic signed [PROD_W-1:0]  acc_q, acc_d;
  logic signed [MID_W-1:0]   inner_q, inner_d;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      clip_q, clip_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0] out_drive_q, out_drive_d;
  logic                      out_clip_q, out_clip_d;

  logic signed [EW-1:0]      e_in;
  logic                      in_accept;
  logic                      out_load;

  smul_ctrl_t                mul_ctrl;
  logic signed [MCAND_W-1:0] mul_mcand;
  logic [MPLR_W-1:0]         mul_mplr;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [PROD_W-1:0]  prod_sh16;
  logic signed [PROD_W-1:0]  prod_sh8;

  assign isum_unused = '0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= 16'd256;
      gain_integ_q <= 16'd0;
      gain_deriv_q <= 16'd0;
      period_q     <= 16'd655;
      inv_period_q <= 16'd25600;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        REG_GAIN_INTEG: gain_integ_q <= cfg_data_i;
        REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        REG_PERIOD:     period_q     <= cfg_data_i;
        REG_INV_PERIOD: inv_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign e_in      = EW'(target_i) - EW'(measured_i);
  assign prod_sh16 = mul_prod >>> 16;
  assign prod_sh8  = mul_prod >>> 8;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_ctrl  = '0;
    mul_mcand = '0;
    mul_mplr  = '0;
    unique case (state_q)
      ST_MD: begin
        mul_ctrl.start = 1'b1;
        mul_mcand      = MCAND_W'(diff_q);
        mul_mplr       = inv_period_q;
      end
      ST_MI: begin
        mul_ctrl.start = 1'b1;
        mul_mcand      = MCAND_W'(e_q);
        mul_mplr       = period_q;
      end
      ST_MK: begin
        mul_ctrl       = '{start: 1'b1, mplr_signed: 1'b1};
        mul_mcand      = MCAND_W'(integral_q);
        mul_mplr       = gain_integ_q;
      end
      ST_ML: begin
        mul_ctrl       = '{start: 1'b1, mplr_signed: 1'b1};
        mul_mcand      = deriv_q;
        mul_mplr       = gain_deriv_q;
      end
      ST_MP: begin
        mul_ctrl       = '{start: 1'b1, mplr_signed: 1'b1};
        mul_mcand      = inner_q;
        mul_mplr       = gain_prop_q;
      end
      default: ;
    endcase
  end

  dpid_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mul_ctrl),
    .mcand_i (mul_mcand),
    .mplr_i  (mul_mplr),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    state_d      = state_q;
    last_error_d = last_error_q;
    integral_d   = integral_q;
    e_d          = e_q;
    diff_d       = diff_q;
    deriv_d      = deriv_q;
    isum_d       = isum_q;
    acc_d        = acc_q;
    inner_d      = inner_q;
    drive_d      = drive_q;
    clip_d       = clip_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          e_d     = e_in;
          diff_d  = DW'(e_in) - DW'(last_error_q);
          clip_d  = 1'b0;
          state_d = ST_MD;
        end
      end
      ST_MD:   state_d = ST_WD;
      ST_WD: begin
        if (mul_done) begin
          // Derivative saturates to the signed 48-bit intermediate range.
          if ((&mul_prod[PROD_W-1:MID_W-1]) || !(|mul_prod[PROD_W-1:MID_W-1])) begin
            deriv_d = mul_prod[MID_W-1:0];
          end else begin
            deriv_d = mul_prod[PROD_W-1] ? {1'b1, {(MID_W-1){1'b0}}}
                                         : {1'b0, {(MID_W-1){1'b1}}};
            clip_d  = 1'b1;
          end
          state_d = ST_MI;
        end
      end
      ST_MI:   state_d = ST_WI;
      ST_WI: begin
        if (mul_done) begin
          isum_d  = (PROD_W+1)'(integral_q) + (PROD_W+1)'(mul_prod);
          state_d = ST_CI;
        end
      end
      ST_CI: begin
        if ((&isum_q[PROD_W:INTEG_W-1]) || !(|isum_q[PROD_W:INTEG_W-1])) begin
          integral_d = isum_q[INTEG_W-1:0];
        end else begin
          integral_d = isum_q[PROD_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
          clip_d     = 1'b1;
        end
        state_d = ST_MK;
      end
      ST_MK:   state_d = ST_WK;
      ST_WK: begin
        if (mul_done) begin
          acc_d   = (PROD_W'(e_q) <<< 8) + prod_sh16;
          state_d = ST_ML;
        end
      end
      ST_ML:   state_d = ST_WL;
      ST_WL: begin
        if (mul_done) begin
          acc_d   = acc_q + prod_sh8;
          state_d = ST_CL;
        end
      end
      ST_CL: begin
        if ((&acc_q[PROD_W-1:MID_W-1]) || !(|acc_q[PROD_W-1:MID_W-1])) begin
          inner_d = acc_q[MID_W-1:0];
        end else begin
          inner_d = acc_q[PROD_W-1] ? {1'b1, {(MID_W-1){1'b0}}}
                                    : {1'b0, {(MID_W-1){1'b1}}};
          clip_d  = 1'b1;
        end
        state_d = ST_MP;
      end
      ST_MP:   state_d = ST_WP;
      ST_WP: begin
        if (mul_done) begin
          // Drive is the product shifted down 16 and clamped to 16 bits.
          if ((&mul_prod[PROD_W-1:DRIVE_W+15]) || !(|mul_prod[PROD_W-1:DRIVE_W+15])) begin
            drive_d = mul_prod[DRIVE_W+15:16];
          end else begin
            drive_d = mul_prod[PROD_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                         : {1'b0, {(DRIVE_W-1){1'b1}}};
            clip_d  = 1'b1;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          last_error_d = e_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_drive_d = out_drive_q;
    out_clip_d  = out_clip_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_drive_d = drive_q;
      out_clip_d  = clip_q;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_error_q <= '0;
      integral_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_error_q <= last_error_d;
      integral_q   <= integral_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q         <= e_d;
    diff_q      <= diff_d;
    deriv_q     <= deriv_d;
    isum_q      <= isum_d + (PROD_W+1)'(isum_unused);
    acc_q       <= acc_d;
    inner_q     <= inner_d;
    drive_q     <= drive_d;
    clip_q      <= clip_d;
    out_drive_q <= out_drive_d;
    out_clip_q  <= out_clip_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign clipped_o   = out_clip_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WD || state_q == ST_WI || state_q == ST_WK ||
                  state_q == ST_WL || state_q == ST_WP))
    else $error("multiplier result arrived outside a wait step");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished request");

  a_error_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_load) |=> last_error_q == $past(e_q))
    else $error("previous error not updated at the end of a request");

endmodule

`default_nettype wire

// ----- src/dpid_smul.sv -----
// Shift-add serial multiplier: one multiplier bit per cycle, product shifted right.
// Depends on dpid_pkg for operand widths and the request struct.
`default_nettype none

module dpid_smul (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire dpid_pkg::smul_ctrl_t                 ctrl_i,
  input  wire logic signed [dpid_pkg::MCAND_W-1:0]  mcand_i,
  input  wire logic        [dpid_pkg::MPLR_W-1:0]   mplr_i,
  output logic                                      done_o,
  output logic signed      [dpid_pkg::PROD_W-1:0]   prod_o
);
  import dpid_pkg::*;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      sgn_q, sgn_d;
  logic signed [MCAND_W-1:0] mcand_q, mcand_d;
  logic signed [MCAND_W:0]   h_q, h_d;
  logic [MPLR_W-1:0]         l_q, l_d;
  logic signed [MCAND_W:0]   mext;
  logic signed [MCAND_W:0]   sum;
  logic                      last_step;

  assign mext      = {mcand_q[MCAND_W-1], mcand_q};
  assign last_step = (cnt_q == CNT_W'(MPLR_W - 1));

  always_comb begin
    // For a signed multiplier the top bit weighs negative, so it subtracts.
    priority if (!l_q[0]) begin
      sum = h_q;
    end else if (last_step && sgn_q) begin
      sum = h_q - mext;
    end else begin
      sum = h_q + mext;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    sgn_d   = sgn_q;
    mcand_d = mcand_q;
    h_d     = h_q;
    l_d     = l_q;
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      sgn_d   = ctrl_i.mplr_signed;
      mcand_d = mcand_i;
      h_d     = '0;
      l_d     = mplr_i;
    end else if (busy_q) begin
      h_d   = {sum[MCAND_W], sum[MCAND_W:1]};
      l_d   = {sum[0], l_q[MPLR_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sgn_q   <= sgn_d;
    mcand_q <= mcand_d;
    h_q     <= h_d;
    l_q     <= l_d;
  end

  assign done_o = done_q;
  assign prod_o = {h_q[MCAND_W-1:0], l_q};

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("multiplier done without a finished run");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("multiplier bit count not parked at zero");

endmodule

`default_nettype wire

// ----- tb/sv/dpid_tick_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the discrete PID controller: follows register writes and accepted
// requests, predicts each drive command and compares it with the output channel.
// Depends on dpid_pkg only.
module dpid_tick_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpid_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    target_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [dpid_pkg::DRIVE_W-1:0] drive_i,
  input  logic                              clipped_i,
  output int unsigned                       mismatches_o,
  output int unsigned                       drives_due_o
);
  import dpid_pkg::*;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clipped;
  } drive_cmd_t;

  localparam logic [GAIN_W-1:0] KP_RESET         = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RESET         = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RESET         = 16'd0;
  localparam logic [GAIN_W-1:0] PERIOD_RESET     = 16'd655;
  localparam logic [GAIN_W-1:0] INV_PERIOD_RESET = 16'd25600;

  logic signed [GAIN_W-1:0]       kp;
  logic signed [GAIN_W-1:0]       ki;
  logic signed [GAIN_W-1:0]       kd;
  logic [GAIN_W-1:0]              period_q16;
  logic [GAIN_W-1:0]              inv_period_q8;
  logic signed [SAMPLE_WIDTH:0]   prev_error;
  logic signed [INTEG_W-1:0]      integral_q16;
  drive_cmd_t                     expected_q[$];
  int unsigned                    mismatch_count = 0;
  int unsigned                    drives_checked = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) begin
      $display("MISMATCH at %0t, drive #%0d: %s", $time, drives_checked, what);
    end
    mismatch_count++;
  endtask

  function automatic longint clamp_signed(input longint v, input int unsigned w,
                                          inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One control tick. Shifts on signed operands floor toward minus infinity.
  task automatic predict_drive(input logic signed [SAMPLE_WIDTH-1:0] tgt,
                               input logic signed [SAMPLE_WIDTH-1:0] meas,
                               output drive_cmd_t cmd);
    longint err;
    longint deriv;
    longint integ;
    longint inner;
    longint drive;
    logic   hit;
    hit   = 1'b0;
    err   = longint'(tgt) - longint'(meas);
    deriv = clamp_signed((err - longint'(prev_error)) * longint'(inv_period_q8), MID_W, hit);
    integ = clamp_signed(longint'(integral_q16) + err * longint'(period_q16), INTEG_W, hit);
    inner = err * 256 + ((longint'(ki) * integ) >>> 16) + ((longint'(kd) * deriv) >>> 8);
    inner = clamp_signed(inner, MID_W, hit);
    drive = clamp_signed((longint'(kp) * inner) >>> 16, DRIVE_W, hit);
    integral_q16 = integ[INTEG_W-1:0];
    prev_error   = err[SAMPLE_WIDTH:0];
    cmd.drive    = drive[DRIVE_W-1:0];
    cmd.clipped  = hit;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    drive_cmd_t cmd;
    if (!rst_ni) begin
      kp            = KP_RESET;
      ki            = KI_RESET;
      kd            = KD_RESET;
      period_q16    = PERIOD_RESET;
      inv_period_q8 = INV_PERIOD_RESET;
      prev_error    = '0;
      integral_q16  = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_PROP:  kp = cfg_data_i;
          REG_GAIN_INTEG: ki = cfg_data_i;
          REG_GAIN_DERIV: kd = cfg_data_i;
          REG_PERIOD:     period_q16 = cfg_data_i;
          REG_INV_PERIOD: inv_period_q8 = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d arrived with no request outstanding",
                                    drive_i));
        end else begin
          cmd = expected_q.pop_front();
          if (drive_i !== cmd.drive) begin
            report_mismatch($sformatf("drive %0d, predicted %0d", drive_i, cmd.drive));
          end
          if (clipped_i !== cmd.clipped) begin
            report_mismatch($sformatf("clipped %0b, predicted %0b", clipped_i, cmd.clipped));
          end
        end
        drives_checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_drive(target_i, measured_i, cmd);
        expected_q.push_back(cmd);
      end
    end
    drives_due_o <= expected_q.size();
  end

endmodule

// ----- tb/sv/discrete_pid_controller_top_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the discrete PID controller: register settings, control
// ticks and random idling on both channels. Depends on dpid_pkg, the block and dpid_tick_checker.
module discrete_pid_controller_top_tb;
  import dpid_pkg::*;

  localparam int unsigned SW          = 16;
  localparam int unsigned TICK_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned TAIL_CYCLES = 200;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [SW-1:0]  target   = '0;
  logic signed [SW-1:0]  measured = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] drive;
  logic                  clipped;
  int unsigned           mismatches;
  int unsigned           drives_due;
  int unsigned           ticks_sent   = 0;
  int unsigned           cycle_count  = 0;
  bit                    sender_idles = 1'b1;
  bit                    quiet        = 1'b0;
  bit                    hold_request = 1'b0;

  discrete_pid_controller_top #(
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .target_i   (target),
    .measured_i (measured),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .drive_o    (drive),
    .clipped_o  (clipped)
  );

  dpid_tick_checker #(
    .SAMPLE_WIDTH(SW)
  ) checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .target_i    (target),
    .measured_i  (measured),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .drive_i     (drive),
    .clipped_i   (clipped),
    .mismatches_o(mismatches),
    .drives_due_o(drives_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_gains(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                             input logic [CFG_DATA_W-1:0] kd, input logic [CFG_DATA_W-1:0] per,
                             input logic [CFG_DATA_W-1:0] inv);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_PERIOD, per);
    write_reg(REG_INV_PERIOD, inv);
    cfg_we <= 1'b0;
  endtask

  // Valid stays high after acceptance unless an idle burst follows.
  task automatic send_tick(input logic signed [SW-1:0] tgt, input logic signed [SW-1:0] meas);
    int unsigned gap;
    in_valid <= 1'b1;
    target   <= tgt;
    measured <= meas;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The checker's count is registered, so look only after the next edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    int unsigned span;
    int unsigned held;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
        hold_request = 1'b0;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 20);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 12);
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] m;
    int                   setpoint;
    int                   plant;
    int unsigned          phase_len;
    int unsigned          phase_no;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: unity gain, so large errors already clip the drive.
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sh8000, 16'sh8000);
    send_tick(16'sh7FFF, 16'sh7FFF);
    send_tick(16'sd100, 16'sd90);
    send_tick(-16'sd1, 16'sd0);
    send_tick(16'sd1, -16'sd1);
    wait_drained();

    // A zero period freezes the integral and a zero inverse period kills the derivative.
    apply_gains(16'd256, 16'd128, 16'd64, 16'd0, 16'd0);
    send_tick(16'sd500, 16'sd0);
    send_tick(-16'sd500, 16'sd200);
    send_tick(16'sh7FFF, 16'sh8000);
    wait_drained();

    // Writes to unmapped indexes must leave every register as it was.
    for (int unsigned i = REG_INV_PERIOD + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(i[CFG_IDX_W-1:0], 16'($urandom));
    end
    cfg_we <= 1'b0;
    send_tick(16'sd1000, -16'sd1000);
    send_tick(16'sd0, 16'sd1234);
    wait_drained();

    apply_gains(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd12345, -16'sd4321);
    wait_drained();

    apply_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001);
    send_tick(16'sh7FFF, 16'sh8000);
    send_tick(16'sd3, -16'sd3);
    send_tick(16'sh8000, 16'sh7FFF);
    wait_drained();

    // Wind the integral into its positive limit, then drive it through to the negative one.
    apply_gains(16'd256, 16'd256, 16'd0, 16'hFFFF, 16'd25600);
    repeat (150) begin
      send_tick(SW'(32767 - int'($urandom_range(0, 255))),
                SW'(int'($urandom_range(0, 255)) - 32768));
    end
    repeat (300) begin
      send_tick(SW'(int'($urandom_range(0, 255)) - 32768),
                SW'(32767 - int'($urandom_range(0, 255))));
    end

    phase_no = 0;
    plant    = 0;
    while (ticks_sent < TICK_TARGET) begin
      wait_drained();
      apply_gains(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value(),
                  pick_reg_value());
      phase_len = $urandom_range(40, 120);
      if (TICK_TARGET - ticks_sent <= 120) begin
        quiet     = 1'b1;
        phase_len = TICK_TARGET - ticks_sent;
      end
      sender_idles = !quiet && ($urandom_range(0, 2) != 0);
      if (!quiet && (phase_no == 1 || phase_no == 5)) hold_request = 1'b1;
      setpoint = int'($urandom_range(0, 60000)) - 30000;
      repeat (phase_len) begin
        case ($urandom_range(0, 7))
          0: begin
            t = SW'($urandom);
            m = SW'($urandom);
          end
          1: begin
            t = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            m = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          end
          2: begin
            t = SW'(int'($urandom_range(0, 200)) - 100);
            m = SW'(int'($urandom_range(0, 200)) - 100);
          end
          default: begin
            // Closed loop: the measured speed creeps toward the set point with some noise.
            if ($urandom_range(0, 31) == 0) setpoint = int'($urandom_range(0, 60000)) - 30000;
            plant = plant + ((setpoint - plant) >>> 2) + int'($urandom_range(0, 16)) - 8;
            t = SW'(setpoint);
            m = SW'(plant);
          end
        endcase
        send_tick(t, m);
      end
      phase_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dpid_pkg.sv
src/dpid_smul.sv
src/discrete_pid_controller_top.sv
tb/sv/dpid_tick_checker.sv
tb/sv/discrete_pid_controller_top_tb.sv
